>>> rtl/psp_pkg.sv
// Package of the preamble and SMD parser: header length, octet codes, the kind
// enum, the code tables and the structs passed between the parser modules.
// Depends on nothing.
package psp_pkg;

	// Octets ahead of the start delimiter; the header is one octet longer.
	localparam int PreambleLen = 7;
	// One cell per header position, plus one that holds the header-done token.
	localparam int NumCells = PreambleLen + 2;

	localparam logic [7:0] OctPre     = 8'h55;
	localparam logic [7:0] OctSfd     = 8'hD5;
	localparam logic [7:0] OctVerify  = 8'h07;
	localparam logic [7:0] OctRespond = 8'h19;

	typedef logic [7:0] psp_code_tab_t [4];

	// SMD-S codes and fragment counts share one table; SMD-C codes have their own.
	localparam psp_code_tab_t StartCodes = '{8'hE6, 8'h4C, 8'h7F, 8'hB3};
	localparam psp_code_tab_t ContCodes  = '{8'h61, 8'h52, 8'h9E, 8'h2A};

	typedef enum logic [2:0] {
		KindSfd     = 3'd0,
		KindVerify  = 3'd1,
		KindRespond = 3'd2,
		KindSmdS    = 3'd3,
		KindSmdC    = 3'd4
	} psp_kind_t;

	// Token and running preamble check handed from one cell to the next.
	typedef struct packed {
		logic tok;
		logic good;
	} psp_link_t;

	// One parsed header.
	typedef struct packed {
		psp_kind_t  kind;
		logic [1:0] smd;
		logic [1:0] frag;
		logic       err;
	} psp_res_t;

	// Result of a table lookup: the index, or index 0 with miss set.
	typedef struct packed {
		logic [1:0] idx;
		logic       miss;
	} psp_lookup_t;

	function automatic psp_lookup_t find_code(input psp_code_tab_t tab, input logic [7:0] v);
		psp_lookup_t r;
		r.idx  = 2'd0;
		r.miss = 1'b1;
		for (int i = 3; i >= 0; i--) begin
			if (tab[i] == v) begin
				r.idx  = 2'(i);
				r.miss = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/preamble_smd_parser_top.sv
// An accepted final octet registers its result in the output register or skid entry.
// Throughput: one octet per cycle; a chain of position cells passes a token per octet.
// The input stalls only while both the output register and its skid entry hold results.
// Reset puts the token at position 0 with the preamble check clean and the kept octet 0.
// Top level of the preamble and SMD parser; uses psp_pkg, psp_cell,
// psp_classify and psp_out_skid.
module preamble_smd_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_octet,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] preamble_kind,
	output logic [1:0] smd_index,
	output logic [1:0] fragment_index,
	output logic       header_error
);

	localparam int PenPos  = psp_pkg::PreambleLen - 1;
	localparam int LastPos = psp_pkg::PreambleLen;
	localparam int DonePos = psp_pkg::NumCells - 1;

	psp_pkg::psp_link_t links [psp_pkg::NumCells];
	logic [psp_pkg::NumCells-1:0] toks;
	logic              adv;
	logic              octet_ok;
	logic              res_valid;
	logic [7:0]        pen_q;
	psp_pkg::psp_res_t res;
	psp_pkg::psp_res_t out_res;
	logic              skid_full;

	assign adv      = in_valid & ~in_stall;
	assign in_stall = skid_full;
	assign octet_ok = (rx_octet == psp_pkg::OctPre);

	// Chain of position cells; early positions check for preamble octets.
	for (genvar k = 0; k < psp_pkg::NumCells; k++) begin : g_cell
		psp_pkg::psp_link_t prev;
		if (k == 0) begin : g_head
			assign prev = '0;
		end else begin : g_body
			assign prev = links[k-1];
		end
		psp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.start    (frame_start),
			.first    (1'(k == 0)),
			.check    (1'(k < PenPos)),
			.hold     (1'(k == DonePos)),
			.octet_ok (octet_ok),
			.prev     (prev),
			.link     (links[k])
		);
		assign toks[k] = links[k].tok;
	end

	// Keep the octet just ahead of the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= 8'h00;
		end else if (adv && links[PenPos].tok) begin
			pen_q <= rx_octet;
		end
	end

	psp_classify u_classify (
		.octet (rx_octet),
		.pen   (pen_q),
		.good  (links[LastPos].good),
		.res   (res)
	);

	assign res_valid = adv & links[LastPos].tok;

	psp_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign preamble_kind  = 3'(out_res.kind);
	assign smd_index      = out_res.smd;
	assign fragment_index = out_res.frag;
	assign header_error   = out_res.err;

	// Exactly one cell holds the position token.
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(toks))
		else $error("position token is not one-hot");

	// After a final octet the token rests in the done cell until a start flag.
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (toks[DonePos] || frame_start))
		else $error("token left the done cell without a start flag");

	// A result in the skid entry implies one in the output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |-> out_valid)
		else $error("skid entry full while output register is empty");

	// A result is never produced while the input is stalled.
	a_no_result_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !skid_full)
		else $error("result produced while the skid entry is full");

endmodule

>>> rtl/psp_cell.sv
// One position cell of the parser chain: holds the position token and the
// preamble check result, and hands both to the next cell on every accepted octet.
// Depends on psp_pkg.
module psp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                start,
	input  logic                first,
	input  logic                check,
	input  logic                hold,
	input  logic                octet_ok,
	input  psp_pkg::psp_link_t  prev,
	output psp_pkg::psp_link_t  link
);

	logic tok_q;
	logic good_q;
	logic tok;
	logic good;

	// The first cell stores its token inverted, so reset leaves the token there.
	// A start flag moves the token to the first cell and clears the error.
	always_comb begin
		tok       = start ? first : (tok_q ^ first);
		good      = start | good_q;
		link.tok  = tok;
		link.good = good & (~check | octet_ok);
	end

	// Take the token from the neighbor; the last cell also keeps its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			good_q <= 1'b1;
		end else if (adv) begin
			tok_q <= (prev.tok | (hold & tok)) ^ first;
			if (prev.tok) begin
				good_q <= prev.good;
			end
		end
	end

endmodule

>>> rtl/psp_classify.sv
// Classification of the final header octet: SFD, Verify, Respond, SMD-S or
// SMD-C, with table lookups and the error flag.
// Depends on psp_pkg.
module psp_classify (
	input  logic [7:0]        octet,
	input  logic [7:0]        pen,
	input  logic              good,
	output psp_pkg::psp_res_t res
);

	psp_pkg::psp_lookup_t start_lu;
	psp_pkg::psp_lookup_t cont_lu;
	psp_pkg::psp_lookup_t frag_lu;

	assign start_lu = psp_pkg::find_code(psp_pkg::StartCodes, octet);
	assign cont_lu  = psp_pkg::find_code(psp_pkg::ContCodes, pen);
	assign frag_lu  = psp_pkg::find_code(psp_pkg::StartCodes, octet);

	// The final octet decides the kind first, then the penultimate octet.
	always_comb begin
		res.kind = psp_pkg::KindSfd;
		res.smd  = 2'd0;
		res.frag = 2'd0;
		res.err  = ~good;
		if (octet == psp_pkg::OctSfd) begin
			res.err = ~good | (pen != psp_pkg::OctPre);
		end else if (pen == psp_pkg::OctPre) begin
			if (octet == psp_pkg::OctVerify) begin
				res.kind = psp_pkg::KindVerify;
			end else if (octet == psp_pkg::OctRespond) begin
				res.kind = psp_pkg::KindRespond;
			end else begin
				res.kind = psp_pkg::KindSmdS;
				res.smd  = start_lu.idx;
				res.err  = ~good | start_lu.miss;
			end
		end else begin
			res.kind = psp_pkg::KindSmdC;
			res.smd  = cont_lu.idx;
			res.frag = frag_lu.idx;
			res.err  = ~good | cont_lu.miss | frag_lu.miss;
		end
	end

endmodule

>>> rtl/psp_out_skid.sv
// Output register with one skid entry for the parsed header results.
// Depends on psp_pkg.
module psp_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  psp_pkg::psp_res_t res,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output psp_pkg::psp_res_t out_res
);

	logic              out_valid_q;
	logic              skid_valid_q;
	psp_pkg::psp_res_t out_q;
	psp_pkg::psp_res_t skid_q;
	logic              out_take;

	assign out_take  = out_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Valid flags: a new result goes to the output register when it is free
	// or being taken, otherwise into the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload moves with the flags above.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

endmodule
